// ===== rtl/generational_handle_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// generational handle allocator assertion macros
// implication checks on the top level, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define GHA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("gha: check failed");

// next-cycle implication
`define GHA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("gha: check failed");

`else

`define GHA_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define GHA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/gha_pkg.sv =====
// ----------------------------------------------------------------------------
// gha_pkg
// shared codes, field widths and controller/datapath interface types
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int SLOT_COUNT_DEF    = 1024;
  localparam int VERSION_LIMIT_DEF = 255;

  // fixed field widths of the request and result
  localparam int SLOT_FIELD_W = 10;
  localparam int VER_FIELD_W  = 8;
  localparam int ACT_W        = 2;
  localparam int STAT_W       = 2;
  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 24;

  typedef enum logic [ACT_W-1:0] {
    ACT_CREATE      = 2'd0,
    ACT_DESTROY     = 2'd1,
    ACT_DESTROY_ALL = 2'd2,
    ACT_QUERY       = 2'd3
  } act_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EXHAUSTED = 2'd2,
    STAT_STALE     = 2'd3
  } stat_t;

  typedef struct packed {
    logic accept;  // take request, launch table read
    logic exec;    // decide, first write, load result
    logic link2;   // second link write of a destroy
    logic sweep;   // one step of the destroy-all relink
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic need_link2;
    logic need_sweep;
    logic sweep_last;
  } sts_t;

endpackage

// ===== rtl/gha_ram.sv =====
// ----------------------------------------------------------------------------
// gha_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/gha_ctrl.sv =====
// ----------------------------------------------------------------------------
// gha_ctrl
// request sequencer: accept, execute, second link write, relink sweep
// ----------------------------------------------------------------------------
module gha_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  gha_pkg::sts_t sts,
  output gha_pkg::cmd_t cmd
);

  import gha_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_LINK2 = 4'b0100,
    ST_SWEEP = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // wait here while the previous result is still held
        if (sts.out_free) begin
          cmd.exec = 1'b1;
          priority if (sts.need_link2) begin
            state_nxt = ST_LINK2;
          end else if (sts.need_sweep) begin
            state_nxt = ST_SWEEP;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_LINK2: begin
        cmd.link2 = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/gha_dp.sv =====
// ----------------------------------------------------------------------------
// gha_dp
// slot table datapath: link and version rams, free list registers, result
// ----------------------------------------------------------------------------
module gha_dp #(
  parameter int SLOT_COUNT    = gha_pkg::SLOT_COUNT_DEF,
  parameter int VERSION_LIMIT = gha_pkg::VERSION_LIMIT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [gha_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [gha_pkg::ACT_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [gha_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  gha_pkg::cmd_t                   cmd,
  output gha_pkg::sts_t                   sts
);

  import gha_pkg::*;

  localparam int SW = $clog2(SLOT_COUNT);        // slot address
  localparam int CW = $clog2(SLOT_COUNT + 1);    // counts, links, none marker
  localparam int VW = $clog2(VERSION_LIMIT + 1); // stored version
  localparam int MW = (CW > SLOT_FIELD_W) ? CW : SLOT_FIELD_W;
  localparam int XW = (VW > VER_FIELD_W) ? VW : VER_FIELD_W;
  localparam logic [CW-1:0] NONE = CW'(SLOT_COUNT);
  localparam logic [VW-1:0] VLIM = VW'(VERSION_LIMIT);

  // request
  act_t                    req_act_r;
  logic [SLOT_FIELD_W-1:0] req_slot_r;
  logic [VER_FIELD_W-1:0]  req_ver_r;

  // free list and fill state
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] head_r, head_nxt;
  logic [CW-1:0] tail_r, tail_nxt;
  logic [SW-1:0] sweep_r, sweep_nxt;

  // result register
  logic                    out_valid_r;
  logic [SLOT_FIELD_W-1:0] res_slot_r, res_slot_nxt;
  logic [VER_FIELD_W-1:0]  res_ver_r, res_ver_nxt;
  logic                    alive_r, alive_nxt;
  logic                    valid_r, valid_nxt;
  stat_t                   status_r, status_nxt;

  // rams
  logic          link_we, ver_we, rd_en;
  logic [SW-1:0] link_waddr, ver_waddr, rd_addr;
  logic [CW-1:0] link_wdata, link_q;
  logic [VW-1:0] ver_wdata, ver_q;

  // decode
  logic          fresh, full, exhausted, list_empty;
  logic          in_range, in_use, ver_match, dest_ok;
  logic [VW-1:0] ver_inc;
  logic [CW-1:0] req_slot_c;
  logic [CW-1:0] sweep_next_c;
  logic          sweep_last;
  act_t          in_act;

  assign in_act = act_t'(in_tuser);
  assign rd_en  = cmd.accept;
  // create reads the free head, all other requests read the handle's slot
  assign rd_addr = (in_act == ACT_CREATE) ? head_r[SW-1:0]
                                          : SW'(in_tdata[SLOT_FIELD_W-1:0]);

  gha_ram #(.WIDTH(CW), .DEPTH(SLOT_COUNT)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (link_q)
  );

  gha_ram #(.WIDTH(VW), .DEPTH(SLOT_COUNT)) u_ver_ram (
    .clk   (clk),
    .we    (ver_we),
    .waddr (ver_waddr),
    .wdata (ver_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ver_q)
  );

  assign req_slot_c = CW'(req_slot_r);
  assign fresh      = (cnt_r == '0) || (head_r >= NONE);
  assign full       = (used_r == NONE);
  assign exhausted  = (ver_q >= VLIM);
  assign ver_inc    = ver_q + VW'(1);
  assign list_empty = (cnt_r == '0) || (tail_r >= NONE);
  assign in_range   = MW'(req_slot_r) < MW'(used_r);
  assign in_use     = in_range && (link_q == req_slot_c);
  assign ver_match  = XW'(ver_q) == XW'(req_ver_r);
  assign dest_ok    = in_use && ver_match;

  assign sweep_next_c = CW'(sweep_r) + CW'(1);
  assign sweep_last   = (sweep_next_c == used_r);

  assign sts.out_free   = !out_valid_r || out_tready;
  assign sts.need_link2 = (req_act_r == ACT_DESTROY) && dest_ok;
  assign sts.need_sweep = (req_act_r == ACT_DESTROY_ALL) && (cnt_r != used_r);
  assign sts.sweep_last = sweep_last;

  // result fields
  always_comb begin
    res_slot_nxt = '0;
    res_ver_nxt  = '0;
    alive_nxt    = 1'b0;
    valid_nxt    = 1'b0;
    status_nxt   = STAT_OK;
    unique case (req_act_r)
      ACT_CREATE: begin
        if (fresh) begin
          if (full) begin
            status_nxt = STAT_FULL;
          end else begin
            res_slot_nxt = SLOT_FIELD_W'(used_r);
          end
        end else if (exhausted) begin
          status_nxt = STAT_EXHAUSTED;
        end else begin
          res_slot_nxt = SLOT_FIELD_W'(head_r);
          res_ver_nxt  = VER_FIELD_W'(ver_inc);
        end
      end
      ACT_DESTROY: begin
        if (!dest_ok) begin
          status_nxt = STAT_STALE;
        end
      end
      ACT_DESTROY_ALL: begin
        status_nxt = STAT_OK;
      end
      ACT_QUERY: begin
        alive_nxt = in_use && ver_match;
        valid_nxt = in_use;
      end
      default: begin
        status_nxt = STAT_OK;
      end
    endcase
  end

  // table writes and free list update
  always_comb begin
    link_we    = 1'b0;
    link_waddr = '0;
    link_wdata = '0;
    ver_we     = 1'b0;
    ver_waddr  = '0;
    ver_wdata  = '0;
    used_nxt   = used_r;
    cnt_nxt    = cnt_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    sweep_nxt  = sweep_r;
    priority if (cmd.sweep) begin
      link_we    = 1'b1;
      link_waddr = sweep_r;
      link_wdata = sweep_last ? NONE : sweep_next_c;
      sweep_nxt  = sweep_r + SW'(1);
    end else if (cmd.link2) begin
      // the destroyed slot ends the list
      link_we    = 1'b1;
      link_waddr = SW'(req_slot_r);
      link_wdata = NONE;
    end else if (cmd.exec) begin
      unique case (req_act_r)
        ACT_CREATE: begin
          if (fresh) begin
            if (!full) begin
              link_we    = 1'b1;
              link_waddr = used_r[SW-1:0];
              link_wdata = used_r;
              ver_we     = 1'b1;
              ver_waddr  = used_r[SW-1:0];
              ver_wdata  = '0;
              used_nxt   = used_r + CW'(1);
            end
          end else if (!exhausted) begin
            link_we    = 1'b1;
            link_waddr = head_r[SW-1:0];
            link_wdata = head_r;
            ver_we     = 1'b1;
            ver_waddr  = head_r[SW-1:0];
            ver_wdata  = ver_inc;
            cnt_nxt    = cnt_r - CW'(1);
            if (cnt_r == CW'(1)) begin
              head_nxt = NONE;
              tail_nxt = NONE;
            end else begin
              head_nxt = link_q;
            end
          end
        end
        ACT_DESTROY: begin
          if (dest_ok) begin
            if (list_empty) begin
              head_nxt = req_slot_c;
            end else begin
              link_we    = 1'b1;
              link_waddr = tail_r[SW-1:0];
              link_wdata = req_slot_c;
            end
            tail_nxt = req_slot_c;
            cnt_nxt  = cnt_r + CW'(1);
          end
        end
        ACT_DESTROY_ALL: begin
          if (cnt_r != used_r) begin
            cnt_nxt   = used_r;
            head_nxt  = '0;
            tail_nxt  = used_r - CW'(1);
            sweep_nxt = '0;
          end
        end
        ACT_QUERY: begin
          sweep_nxt = sweep_r;
        end
        default: begin
          sweep_nxt = sweep_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      cnt_r       <= '0;
      head_r      <= NONE;
      tail_r      <= NONE;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r  <= used_nxt;
      cnt_r   <= cnt_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      sweep_r <= sweep_nxt;
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_act_r  <= in_act;
      req_slot_r <= in_tdata[SLOT_FIELD_W-1:0];
      req_ver_r  <= in_tdata[SLOT_FIELD_W +: VER_FIELD_W];
    end
    if (cmd.exec) begin
      res_slot_r <= res_slot_nxt;
      res_ver_r  <= res_ver_nxt;
      alive_r    <= alive_nxt;
      valid_r    <= valid_nxt;
      status_r   <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, status_r, valid_r, alive_r, res_ver_r, res_slot_r};

endmodule

// ===== rtl/generational_handle_allocator.sv =====
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Hands out handles (slot, version) from a slot table with a fifo free list.
// Request channel in_*: in_tuser carries the action (create, destroy,
// destroy all, query), in_tdata the handle for destroy and query.
// Result channel out_*: one result per request, held in an output register
// until taken; in_tready drops while a request is in flight, and a finished
// result stalled by out_tready holds back the next request's completion.
// Sequence: a request is accepted in idle, executed once the output register
// is free, and its result is registered; a valid destroy adds a second link
// ram write step, and destroy all adds a relink sweep over every used slot
// when a relink is needed (one link ram write port, one entry per cycle).
// Reset: empty table, empty free list, no result pending; the rams need no
// clearing pass since data read from slots at or above the fill count is unused.
// ----------------------------------------------------------------------------
`include "generational_handle_allocator_assert.svh"

module generational_handle_allocator #(
  parameter int SLOT_COUNT    = gha_pkg::SLOT_COUNT_DEF,
  parameter int VERSION_LIMIT = gha_pkg::VERSION_LIMIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // handle_slot[9:0], handle_version[17:10], zero pad
  input  logic [gha_pkg::IN_DATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [gha_pkg::ACT_W-1:0]      in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // result_slot[9:0], result_version[17:10], alive[18], slot_valid[19],
  // status[21:20], zero pad
  output logic [gha_pkg::OUT_DATA_W-1:0] out_tdata
);

  import gha_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gha_dp #(
    .SLOT_COUNT    (SLOT_COUNT),
    .VERSION_LIMIT (VERSION_LIMIT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

  // a request in flight blocks the next one
  `GHA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, (in_tvalid && in_tready), (!in_tready))
  // executing a request always leaves a result in the output register
  `GHA_ASSERT_NEXT(a_exec_loads_result, clk, rst_n, (cmd.exec), (out_tvalid))
  // controller issues at most one command per cycle
  `GHA_ASSERT_NOW(a_one_cmd, clk, rst_n, (1'b1), ($onehot0({cmd.accept, cmd.exec, cmd.link2, cmd.sweep})))

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for generational_handle_allocator. A driver sends queued
// requests and a monitor takes results, both idling at random. Each accepted
// request runs through a local model of the slot table and free list. The
// model's expected result is compared field by field with the block's output.
// Stimulus: directed corner cases, random mixed traffic, a fill to table full,
// traffic on a full table, and a run that uses up one slot's versions.
// ----------------------------------------------------------------------------
module tb_top;
  import gha_pkg::*;

  localparam int SLOTS   = SLOT_COUNT_DEF;
  localparam int VER_MAX = VERSION_LIMIT_DEF;
  localparam logic [10:0] SLOT_NONE = 11'(SLOTS);

  typedef struct packed {
    act_t                   act;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [VER_FIELD_W-1:0]  ver;
  } req_t;

  typedef struct packed {
    logic [SLOT_FIELD_W-1:0] slot;
    logic [VER_FIELD_W-1:0]  ver;
    logic                    alive;
    logic                    valid;
    stat_t                   st;
  } res_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [ACT_W-1:0]      in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // local copy of the slot table
  logic [10:0] lnk_mem [SLOTS];
  logic [7:0]  ver_mem [SLOTS];
  logic [10:0] fill_cnt  = '0;
  logic [10:0] free_cnt  = '0;
  logic [10:0] free_head = SLOT_NONE;
  logic [10:0] free_tail = SLOT_NONE;

  req_t req_q[$];
  res_t want_q[$];
  req_t cur_req;
  int   n_push    = 0;
  int   n_acc     = 0;
  int   n_res     = 0;
  int   n_err     = 0;
  int   hold_left = 0;
  logic held      = 1'b0;
  logic calm      = 1'b0;

  generational_handle_allocator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit slot_live(input logic [SLOT_FIELD_W-1:0] s);
    return (11'(s) < fill_cnt) && (lnk_mem[s] == 11'(s));
  endfunction

  // applies one request to the local table and returns the result it yields
  function automatic res_t alloc_apply(input req_t r);
    res_t        o;
    logic [10:0] s;
    logic [7:0]  v;
    logic        live;
    o.slot  = '0;
    o.ver   = '0;
    o.alive = 1'b0;
    o.valid = 1'b0;
    o.st    = STAT_OK;
    case (r.act)
      ACT_CREATE: begin
        if (free_cnt == 0 || free_head >= SLOTS) begin
          if (fill_cnt >= SLOTS) begin
            o.st = STAT_FULL;
          end else begin
            lnk_mem[fill_cnt] = fill_cnt;
            ver_mem[fill_cnt] = '0;
            o.slot = fill_cnt[SLOT_FIELD_W-1:0];
            fill_cnt = fill_cnt + 1;
          end
        end else begin
          s = free_head;
          v = ver_mem[s];
          if (v >= VER_MAX) begin
            o.st = STAT_EXHAUSTED;
          end else begin
            free_head = lnk_mem[s];
            free_cnt = free_cnt - 1;
            if (free_cnt == 0) begin
              free_head = SLOT_NONE;
              free_tail = SLOT_NONE;
            end
            ver_mem[s] = v + 1;
            lnk_mem[s] = s;
            o.slot = s[SLOT_FIELD_W-1:0];
            o.ver  = v + 1;
          end
        end
      end
      ACT_DESTROY: begin
        if (!slot_live(r.slot) || ver_mem[r.slot] != r.ver) begin
          o.st = STAT_STALE;
        end else begin
          if (free_cnt == 0 || free_tail >= SLOTS) free_head = 11'(r.slot);
          else lnk_mem[free_tail] = 11'(r.slot);
          lnk_mem[r.slot] = SLOT_NONE;
          free_tail = 11'(r.slot);
          free_cnt = free_cnt + 1;
        end
      end
      ACT_DESTROY_ALL: begin
        // relink every used slot in ascending order, versions kept
        if (free_cnt != fill_cnt) begin
          for (int i = 0; i + 1 < fill_cnt; i++) lnk_mem[i] = 11'(i + 1);
          lnk_mem[fill_cnt - 1] = SLOT_NONE;
          free_cnt  = fill_cnt;
          free_head = '0;
          free_tail = fill_cnt - 1;
        end
      end
      default: begin
        live    = slot_live(r.slot);
        o.valid = live;
        o.alive = live && ver_mem[r.slot] == r.ver;
      end
    endcase
    return o;
  endfunction

  task automatic check_result(input logic [OUT_DATA_W-1:0] d);
    res_t want;
    if (want_q.size() == 0) begin
      $error("result with no request outstanding: %h", d);
      n_err++;
    end else begin
      want = want_q.pop_front();
      if (d[9:0] !== want.slot) begin
        $error("result_slot: expected %0d, got %0d", want.slot, d[9:0]);
        n_err++;
      end
      if (d[17:10] !== want.ver) begin
        $error("result_version: expected %0d, got %0d", want.ver, d[17:10]);
        n_err++;
      end
      if (d[18] !== want.alive) begin
        $error("alive: expected %0b, got %0b", want.alive, d[18]);
        n_err++;
      end
      if (d[19] !== want.valid) begin
        $error("slot_valid: expected %0b, got %0b", want.valid, d[19]);
        n_err++;
      end
      if (d[21:20] !== want.st) begin
        $error("status: expected %0d, got %0d", want.st, d[21:20]);
        n_err++;
      end
    end
  endtask

  // driver: the model advances when a request is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        want_q.insert(want_q.size(), alloc_apply(cur_req));
        n_acc <= n_acc + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (req_q.size() != 0 && (calm || $urandom_range(0, 99) >= 32)) begin
          cur_req = req_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {6'b0, cur_req.ver, cur_req.slot};
          in_tuser  <= cur_req.act;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: one long hold-off once enough results have come back
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_result(out_tdata);
        n_res <= n_res + 1;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (!held && n_res >= 600) begin
        held      <= 1'b1;
        hold_left <= 400;
      end
      out_tready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 32);
    end
  end

  task automatic send(input act_t a, input int s, input int v);
    req_t r;
    r.act  = a;
    r.slot = s[SLOT_FIELD_W-1:0];
    r.ver  = v[VER_FIELD_W-1:0];
    req_q.insert(req_q.size(), r);
    n_push++;
  endtask

  task automatic wait_taken(input bit all_back);
    while (n_acc != n_push || (all_back && want_q.size() != 0)) @(posedge clk);
  endtask

  task automatic pick_live(output bit ok, output logic [9:0] s, output logic [7:0] v);
    logic [9:0] c;
    ok = 1'b0;
    s  = '0;
    v  = '0;
    if (fill_cnt != 0) begin
      for (int k = 0; k < 24 && !ok; k++) begin
        c = 10'($urandom_range(0, int'(fill_cnt) - 1));
        if (slot_live(c)) begin
          ok = 1'b1;
          s  = c;
          v  = ver_mem[c];
        end
      end
    end
  endtask

  // mostly well-formed traffic on live handles, some stale and random noise
  task automatic send_random(input bit allow_all);
    int         p;
    bit         ok;
    logic [9:0] s;
    logic [7:0] v;
    act_t       a;
    int         rs;
    int         rv;
    p  = $urandom_range(0, 99);
    a  = ACT_QUERY;
    rs = $urandom_range(0, SLOTS - 1);
    rv = $urandom_range(0, 255);
    pick_live(ok, s, v);
    if (p < 36) begin
      a = ACT_CREATE;
    end else if (p < 62) begin
      a = ACT_DESTROY;
      if (ok) begin
        rs = s;
        rv = v;
      end
    end else if (p < 70) begin
      a = ACT_DESTROY;
      if (ok && p < 67) begin
        rs = s;
        rv = v ^ (8'd1 << $urandom_range(0, 7));
      end
    end else if (p < 83) begin
      if (ok) begin
        rs = s;
        rv = v;
      end
    end else if (p < 88) begin
      if (ok) begin
        rs = s;
        rv = v ^ (8'd1 << $urandom_range(0, 7));
      end
    end else if (allow_all && p >= 97) begin
      a = ACT_DESTROY_ALL;
    end
    send(a, rs, rv);
  endtask

  initial begin
    int k;
    int n;
    int v0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, stale handles, reuse order, destroy all
    send(ACT_QUERY, 0, 0);
    send(ACT_DESTROY, 0, 0);
    send(ACT_DESTROY_ALL, 0, 0);
    send(ACT_CREATE, 1023, 255);
    send(ACT_CREATE, 0, 0);
    send(ACT_CREATE, 0, 0);
    send(ACT_QUERY, 1, 0);
    send(ACT_QUERY, 1, 5);
    send(ACT_QUERY, 3, 0);
    send(ACT_DESTROY, 1, 7);
    send(ACT_DESTROY, 1, 0);
    send(ACT_DESTROY, 1, 0);
    send(ACT_QUERY, 1, 0);
    send(ACT_DESTROY, 0, 0);
    send(ACT_CREATE, 0, 0);
    send(ACT_CREATE, 0, 0);
    send(ACT_CREATE, 0, 0);
    send(ACT_DESTROY_ALL, 0, 0);
    send(ACT_DESTROY_ALL, 0, 0);
    send(ACT_CREATE, 0, 0);
    send(ACT_QUERY, 1023, 255);
    send(ACT_DESTROY, 1023, 255);
    send(ACT_CREATE, 0, 0);
    wait_taken(1'b1);

    // random traffic in small batches built from the current table
    k = 0;
    while (k < 80) begin
      n = $urandom_range(1, 6);
      repeat (n) send_random(1'b1);
      k += n;
      wait_taken($urandom_range(0, 9) == 0);
    end
    wait_taken(1'b1);

    // fill to table full; the monitor's hold-off falls in here
    n = SLOTS - int'(fill_cnt) + int'(free_cnt) + 3;
    repeat (n) begin
      send(ACT_CREATE, $urandom_range(0, SLOTS - 1), $urandom_range(0, 255));
      if ($urandom_range(0, 31) == 0)
        send(ACT_QUERY, $urandom_range(0, SLOTS - 1), $urandom_range(0, 255));
    end
    wait_taken(1'b1);

    // traffic on a full table, no destroy all so the table stays nearly full
    k = 0;
    while (k < 30) begin
      n = $urandom_range(1, 6);
      repeat (n) send_random(1'b0);
      k += n;
      wait_taken(1'b0);
    end
    wait_taken(1'b1);

    // run one slot out of versions with every other slot live
    calm <= 1'b1;
    repeat (int'(free_cnt)) send(ACT_CREATE, 0, 0);
    wait_taken(1'b1);
    n  = $urandom_range(512, SLOTS - 1);
    v0 = ver_mem[n];
    for (int v = v0; v < VER_MAX; v++) begin
      send(ACT_DESTROY, n, v);
      send(ACT_CREATE, 0, 0);
    end
    send(ACT_DESTROY, n, VER_MAX);
    send(ACT_CREATE, 0, 0);
    send(ACT_CREATE, 0, 0);
    send(ACT_QUERY, n, VER_MAX);
    send(ACT_QUERY, n, VER_MAX - 1);
    wait_taken(1'b1);
    calm <= 1'b0;
    send(ACT_DESTROY_ALL, 0, 0);
    repeat (3) send(ACT_CREATE, 0, 0);
    send(ACT_QUERY, 0, 0);
    send(ACT_QUERY, n, VER_MAX);

    wait_taken(1'b1);
    repeat (1100) @(posedge clk);
    if (n_err == 0 && want_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== generational_handle_allocator.f =====
+incdir+rtl
rtl/gha_pkg.sv
rtl/gha_ram.sv
rtl/gha_ctrl.sv
rtl/gha_dp.sv
rtl/generational_handle_allocator.sv
tb/tb_top.sv
